// ===== rtl/core/slcp_pkg.sv =====
package slcp_pkg;

	// command bytes
	localparam logic [7:0] CMD_CHIP_LAST   = 8'h08;
	localparam logic [7:0] CMD_PSG         = 8'h10;
	localparam logic [7:0] CMD_DCSG        = 8'h11;
	localparam logic [7:0] CMD_SKIP1_FIRST = 8'h12;
	localparam logic [7:0] CMD_SKIP1_LAST  = 8'h1F;
	localparam logic [7:0] CMD_SKIP2_FIRST = 8'h80;
	localparam logic [7:0] CMD_END         = 8'hFC;
	localparam logic [7:0] CMD_LOOP        = 8'hFD;
	localparam logic [7:0] CMD_VWAIT       = 8'hFE;
	localparam logic [7:0] CMD_SYNC        = 8'hFF;

	// result kinds
	localparam logic [2:0] KIND_REG  = 3'd0;
	localparam logic [2:0] KIND_DATA = 3'd1;
	localparam logic [2:0] KIND_WAIT = 3'd2;
	localparam logic [2:0] KIND_SEEK = 3'd3;
	localparam logic [2:0] KIND_END  = 3'd4;

	localparam logic [3:0] CHIP_PSG  = 4'd9;
	localparam logic [3:0] CHIP_DCSG = 4'd10;

	// configuration register indexes
	localparam logic [1:0] REG_TIMER_NUM = 2'd0;
	localparam logic [1:0] REG_TIMER_DEN = 2'd1;
	localparam logic [1:0] REG_LOOP_OFS  = 2'd2;

	localparam logic [31:0] PAL_DENOM  = 32'd198;
	localparam logic [31:0] WAIT_NTSC  = 32'd441;
	localparam logic [31:0] WAIT_PAL   = 32'd882;
	// floor(x/10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
	localparam logic [31:0] RECIP_TEN  = 32'hCCCCCCCD;
	localparam int          RECIP_SHIFT = 35;
	// x*441/10 == x*44 + x/10 (441 = 44*10 + 1)
	localparam logic [41:0] VWAIT_WHOLE = 42'd44;

	typedef enum logic [2:0] {
		PH_CMD,
		PH_ADDR,
		PH_DATA,
		PH_DCSG,
		PH_COUNT,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  chip;
		logic [7:0]  addr;
		logic [7:0]  value;
		logic [31:0] count;
		logic        var_wait;
		logic [31:0] seek;
	} event_t;

endpackage

// ===== rtl/core/sound_log_command_parser_top.sv =====
// Command parser for a chip-register sound log. One stream byte is taken per
// cycle while stream_stall is low; each complete command yields at most one
// result beat: register write, data write, flush-and-wait (in 44.1 kHz
// samples), seek to the loop offset, or end. Results pass through ev_s1,
// ev_s2 (after the shared 32x32 wait-count multiplier) and ev_s3; a held
// result_stall backs up to the input. After the end command every byte is
// swallowed until reset. Timer and loop registers are written by the user
// through cfg_we/cfg_index/cfg_data while idle; the block does not enforce it.
module sound_log_command_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        stream_valid,
	output logic        stream_stall,
	input  logic [7:0]  stream_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  result_kind,
	output logic [3:0]  chip_id,
	output logic        chip_port,
	output logic [7:0]  reg_address,
	output logic [7:0]  reg_value,
	output logic [41:0] wait_samples,
	output logic [31:0] seek_offset
);
	import slcp_pkg::*;

	logic [31:0] timer_num_q, timer_den_q, loop_ofs_q;
	logic        pal;
	logic        accept, adv_s1, ev_valid_s1;
	event_t      ev_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_num_q <= 32'd0;
			timer_den_q <= 32'd0;
			loop_ofs_q  <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIMER_NUM: timer_num_q <= cfg_data;
				REG_TIMER_DEN: timer_den_q <= cfg_data;
				REG_LOOP_OFS:  loop_ofs_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pal          = (timer_num_q != 32'd0) && (timer_den_q == PAL_DENOM);
	assign stream_stall = !adv_s1;
	assign accept       = stream_valid && adv_s1;

	slcp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.adv         (adv_s1),
		.stream_byte (stream_byte),
		.loop_offset (loop_ofs_q),
		.ev_valid_s1 (ev_valid_s1),
		.ev_s1       (ev_s1)
	);

	slcp_wait_pipe u_wait (
		.clk          (clk),
		.arst_n       (arst_n),
		.ev_valid_s1  (ev_valid_s1),
		.ev_s1        (ev_s1),
		.pal          (pal),
		.adv_s1       (adv_s1),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_kind  (result_kind),
		.chip_id      (chip_id),
		.chip_port    (chip_port),
		.reg_address  (reg_address),
		.reg_value    (reg_value),
		.wait_samples (wait_samples),
		.seek_offset  (seek_offset)
	);

	// end is the last beat ever produced
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && result_kind == KIND_END |=> !result_valid)
		else $error("result after end beat");

	// input only backs up when the first stage holds an event
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		stream_stall |-> ev_valid_s1)
		else $error("input stalled with empty first stage");

	a_wait_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind != KIND_WAIT |-> wait_samples == 42'd0)
		else $error("wait count on non-wait beat");

	a_seek_loop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_SEEK |-> seek_offset == loop_ofs_q)
		else $error("seek offset differs from loop register");

endmodule

// ===== rtl/core/slcp_parser.sv =====
module slcp_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  adv,
	input  logic [7:0]            stream_byte,
	input  logic [31:0]           loop_offset,
	output logic                  ev_valid_s1,
	output slcp_pkg::event_t      ev_s1
);
	import slcp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  addr_q, addr_d;
	logic [1:0]  skip_q, skip_d;
	logic [31:0] acc_q, acc_d;
	logic [2:0]  grp_q, grp_d;
	logic        stop_q, stop_d;
	logic [31:0] part;
	logic        emit;
	event_t      ev;

	// place the 7-bit group; the fifth group keeps only what fits in 32 bits
	always_comb begin
		case (grp_q)
			3'd0: part = {25'b0, stream_byte[6:0]};
			3'd1: part = {18'b0, stream_byte[6:0], 7'b0};
			3'd2: part = {11'b0, stream_byte[6:0], 14'b0};
			3'd3: part = {4'b0, stream_byte[6:0], 21'b0};
			default: part = {stream_byte[3:0], 28'b0};
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		cmd_d   = cmd_q;
		addr_d  = addr_q;
		skip_d  = skip_q;
		acc_d   = acc_q;
		grp_d   = grp_q;
		stop_d  = stop_q;
		emit    = 1'b0;
		ev      = '0;
		if (!stop_q) begin
			case (phase_q)
				PH_ADDR: begin
					addr_d  = stream_byte;
					phase_d = PH_DATA;
				end
				PH_DATA: begin
					phase_d  = PH_CMD;
					emit     = 1'b1;
					ev.kind  = KIND_REG;
					ev.chip  = (cmd_q == CMD_PSG) ? CHIP_PSG : cmd_q[3:0];
					ev.addr  = addr_q;
					ev.value = stream_byte;
				end
				PH_DCSG: begin
					phase_d  = PH_CMD;
					emit     = 1'b1;
					ev.kind  = KIND_DATA;
					ev.chip  = CHIP_DCSG;
					ev.value = stream_byte;
				end
				PH_COUNT: begin
					acc_d = acc_q | part;
					if (!stream_byte[7] || grp_q >= 3'd4) begin
						phase_d     = PH_CMD;
						grp_d       = 3'd0;
						emit        = 1'b1;
						ev.kind     = KIND_WAIT;
						ev.count    = acc_q | part;
						ev.var_wait = (cmd_q == CMD_VWAIT);
					end else begin
						grp_d = grp_q + 3'd1;
					end
				end
				PH_SKIP: begin
					if (skip_q > 2'd1) begin
						skip_d = skip_q - 2'd1;
					end else begin
						skip_d  = 2'd0;
						phase_d = PH_CMD;
					end
				end
				default: begin
					phase_d = PH_CMD;
					cmd_d   = stream_byte;
					if (stream_byte <= CMD_CHIP_LAST || stream_byte == CMD_PSG) begin
						phase_d = PH_ADDR;
					end else if (stream_byte == CMD_DCSG) begin
						phase_d = PH_DCSG;
					end else if (stream_byte == CMD_SYNC || stream_byte == CMD_VWAIT) begin
						acc_d   = 32'd0;
						grp_d   = 3'd0;
						phase_d = PH_COUNT;
					end else if (stream_byte == CMD_LOOP) begin
						if (loop_offset != 32'd0) begin
							emit    = 1'b1;
							ev.kind = KIND_SEEK;
							ev.seek = loop_offset;
						end
					end else if (stream_byte == CMD_END) begin
						stop_d  = 1'b1;
						emit    = 1'b1;
						ev.kind = KIND_END;
					end else if (stream_byte >= CMD_SKIP1_FIRST &&
							stream_byte <= CMD_SKIP1_LAST) begin
						skip_d  = 2'd1;
						phase_d = PH_SKIP;
					end else if (stream_byte >= CMD_SKIP2_FIRST) begin
						skip_d  = 2'd2;
						phase_d = PH_SKIP;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			cmd_q   <= 8'd0;
			addr_q  <= 8'd0;
			skip_q  <= 2'd0;
			acc_q   <= 32'd0;
			grp_q   <= 3'd0;
			stop_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			addr_q  <= addr_d;
			skip_q  <= skip_d;
			acc_q   <= acc_d;
			grp_q   <= grp_d;
			stop_q  <= stop_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_s1 <= 1'b0;
		end else if (adv) begin
			ev_valid_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && accept && emit) begin
			ev_s1 <= ev;
		end
	end

endmodule

// ===== rtl/core/slcp_wait_pipe.sv =====
module slcp_wait_pipe (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ev_valid_s1,
	input  slcp_pkg::event_t      ev_s1,
	input  logic                  pal,
	output logic                  adv_s1,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [2:0]            result_kind,
	output logic [3:0]            chip_id,
	output logic                  chip_port,
	output logic [7:0]            reg_address,
	output logic [7:0]            reg_value,
	output logic [41:0]           wait_samples,
	output logic [31:0]           seek_offset
);
	import slcp_pkg::*;

	logic        valid_s2, valid_s3;
	logic        adv_s2, adv_s3;
	event_t      ev_s2, ev_s3;
	logic [63:0] prod_s2;
	logic [41:0] wait_s3;
	logic [31:0] mul_a, mul_b;
	logic [41:0] whole, frac, wait_nx;

	assign adv_s3 = !valid_s3 || !result_stall;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !ev_valid_s1 || adv_s2;

	// one shared multiplier: count/10 by reciprocal, or (count+1) * samples per tick
	assign mul_a = ev_s1.var_wait ? ev_s1.count : ev_s1.count + 32'd1;
	assign mul_b = ev_s1.var_wait ? RECIP_TEN : (pal ? WAIT_PAL : WAIT_NTSC);

	assign whole = 42'(ev_s2.count) * VWAIT_WHOLE;
	assign frac  = 42'(prod_s2[63:RECIP_SHIFT]);

	always_comb begin
		if (ev_s2.kind != KIND_WAIT) begin
			wait_nx = 42'd0;
		end else if (ev_s2.var_wait) begin
			wait_nx = whole + frac;
		end else begin
			wait_nx = prod_s2[41:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s2) begin
				valid_s2 <= ev_valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && ev_valid_s1) begin
			ev_s2   <= ev_s1;
			prod_s2 <= 64'(mul_a) * 64'(mul_b);
		end
		if (adv_s3 && valid_s2) begin
			ev_s3   <= ev_s2;
			wait_s3 <= wait_nx;
		end
	end

	assign result_valid = valid_s3;
	assign result_kind  = ev_s3.kind;
	assign chip_id      = ev_s3.chip;
	assign chip_port    = 1'b0;
	assign reg_address  = ev_s3.addr;
	assign reg_value    = ev_s3.value;
	assign wait_samples = wait_s3;
	assign seek_offset  = ev_s3.seek;

endmodule
